FILE: rtl/core/bda_pkg.sv
package bda_pkg;

    localparam int N_ROWS  = 8;
    localparam int N_RES   = 3;
    localparam int CNT_W   = 8;
    localparam int ROW_W   = 3;
    localparam int NUM_W   = 4;
    localparam int WORK_W  = 12;
    localparam int QDEPTH  = 2;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_AVAIL = 2'd1,
        ACT_REQ   = 2'd2,
        ACT_CHECK = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_EXCEEDS = 3'd1,
        ST_WAIT    = 3'd2,
        ST_DENIED  = 3'd3,
        ST_SAFE    = 3'd4,
        ST_UNSAFE  = 3'd5,
        ST_LOADED  = 3'd6,
        ST_BAD_ROW = 3'd7
    } status_t;

    typedef logic [N_RES-1:0][CNT_W-1:0] vec_t;

    // classified command handed from front to back
    typedef struct packed {
        act_t             action;
        logic [ROW_W-1:0] p;
        vec_t             amt;
        vec_t             held;
        logic             bad_row;
    } cmd_t;

endpackage

FILE: rtl/core/bda_if.sv
interface bda_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] process;
    logic [7:0] amount_a;
    logic [7:0] amount_b;
    logic [7:0] amount_c;
    logic [7:0] held_a;
    logic [7:0] held_b;
    logic [7:0] held_c;

    modport source (output valid, action, process, amount_a, amount_b, amount_c,
                    held_a, held_b, held_c, input ready);
    modport sink   (input valid, action, process, amount_a, amount_b, amount_c,
                    held_a, held_b, held_c, output ready);
endinterface

interface bda_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] seq_process;
    logic       seq_valid;
    logic       last;

    modport source (output valid, status, seq_process, seq_valid, last, input ready);
    modport sink   (input valid, status, seq_process, seq_valid, last, output ready);
endinterface

FILE: rtl/core/bda_front.sv
module bda_front (
    input  logic          clk,
    input  logic          rst_n,
    bda_in_if.sink        in_ch,
    output logic          q_valid,
    output bda_pkg::cmd_t q_cmd,
    input  logic          q_pop
);

    bda_pkg::cmd_t mem_reg [bda_pkg::QDEPTH];
    logic          wptr_reg, wptr_next;
    logic          rptr_reg, rptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    bda_pkg::cmd_t cmd_in;
    logic          push;

    // classify the incoming beat
    always_comb
    begin
        cmd_in.action  = bda_pkg::act_t'(in_ch.action);
        cmd_in.p       = in_ch.process;
        cmd_in.amt     = {in_ch.amount_c, in_ch.amount_b, in_ch.amount_a};
        cmd_in.held    = {in_ch.held_c, in_ch.held_b, in_ch.held_a};
        cmd_in.bad_row = (in_ch.held_a > in_ch.amount_a) ||
                         (in_ch.held_b > in_ch.amount_b) ||
                         (in_ch.held_c > in_ch.amount_c);
    end

    assign in_ch.ready = (cnt_reg != 2'(bda_pkg::QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_cmd       = mem_reg[rptr_reg];

    // queue pointers
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: rtl/core/bda_back.sv
module bda_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  bda_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic          cfg_we,
    input  logic [3:0]    cfg_data,
    bda_out_if.source     out_ch
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EMIT = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    localparam int NR = bda_pkg::N_RES;
    localparam int NW = bda_pkg::NUM_W;
    localparam int RW = bda_pkg::ROW_W;
    localparam int WW = bda_pkg::WORK_W;

    state_t             state_reg, state_next;
    bda_pkg::vec_t      alloc_reg [bda_pkg::N_ROWS];
    bda_pkg::vec_t      alloc_next [bda_pkg::N_ROWS];
    bda_pkg::vec_t      need_reg [bda_pkg::N_ROWS];
    bda_pkg::vec_t      need_next [bda_pkg::N_ROWS];
    bda_pkg::vec_t      free_reg, free_next;
    bda_pkg::vec_t      bk_alloc_reg, bk_alloc_next;
    bda_pkg::vec_t      bk_need_reg, bk_need_next;
    logic [NR-1:0][WW-1:0] work_reg, work_next;
    logic [bda_pkg::N_ROWS-1:0] fin_reg, fin_next;
    logic [RW-1:0]      seq_reg [bda_pkg::N_ROWS];
    logic [RW-1:0]      seq_next [bda_pkg::N_ROWS];
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [NW-1:0]      pass_reg, pass_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [RW-1:0]      k_reg, k_next;
    logic               found_reg, found_next;
    logic [2:0]         status_reg, status_next;
    logic [NW-1:0]      active_reg;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_status_reg, out_status_next;
    logic [RW-1:0]      out_seq_reg, out_seq_next;
    logic               out_sv_reg, out_sv_next;
    logic               out_last_reg, out_last_next;

    logic [NW-1:0]      n_act;
    logic [RW-1:0]      n_last;
    logic [RW-1:0]      rd_row;
    bda_pkg::vec_t      rd_need, rd_alloc;
    logic               out_free;
    logic               exceeds, must_wait, fits, end_pass;
    logic [NW-1:0]      cnt_inc, pass_inc;

    // clamp active row count to 1..N_ROWS
    always_comb
    begin
        if (active_reg == '0)
            n_act = NW'(1);
        else if (active_reg > NW'(bda_pkg::N_ROWS))
            n_act = NW'(bda_pkg::N_ROWS);
        else
            n_act = active_reg;
    end

    assign n_last   = RW'(n_act - NW'(1));
    assign rd_row   = (state_reg == S_SCAN) ? row_reg : q_cmd.p;
    assign rd_need  = need_reg[rd_row];
    assign rd_alloc = alloc_reg[rd_row];
    assign out_free = !out_valid_reg || out_ch.ready;
    assign cnt_inc  = cnt_reg + NW'(1);
    assign pass_inc = pass_reg + NW'(1);
    assign end_pass = (row_reg == n_last);

    // request checks and scan row test
    always_comb
    begin
        exceeds   = 1'b0;
        must_wait = 1'b0;
        fits      = !fin_reg[row_reg];
        for (int j = 0; j < NR; j++)
        begin
            if (q_cmd.amt[j] > rd_need[j])
                exceeds = 1'b1;
            if (q_cmd.amt[j] > free_reg[j])
                must_wait = 1'b1;
            if (WW'(rd_need[j]) > work_reg[j])
                fits = 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        alloc_next      = alloc_reg;
        need_next       = need_reg;
        free_next       = free_reg;
        bk_alloc_next   = bk_alloc_reg;
        bk_need_next    = bk_need_reg;
        work_next       = work_reg;
        fin_next        = fin_reg;
        seq_next        = seq_reg;
        cnt_next        = cnt_reg;
        pass_next       = pass_reg;
        row_next        = row_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        q_pop           = 1'b0;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_sv_next     = out_sv_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    // default to a single result beat
                    out_seq_next  = '0;
                    out_sv_next   = 1'b0;
                    out_last_next = 1'b1;
                    case (q_cmd.action)
                        bda_pkg::ACT_LOAD:
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            if (q_cmd.bad_row)
                            begin
                                out_status_next = bda_pkg::ST_BAD_ROW;
                            end
                            else
                            begin
                                out_status_next = bda_pkg::ST_LOADED;
                                alloc_next[q_cmd.p] = q_cmd.held;
                                for (int j = 0; j < NR; j++)
                                    need_next[q_cmd.p][j] = q_cmd.amt[j] - q_cmd.held[j];
                            end
                        end
                        bda_pkg::ACT_AVAIL:
                        begin
                            q_pop           = 1'b1;
                            out_valid_next  = 1'b1;
                            out_status_next = bda_pkg::ST_LOADED;
                            free_next       = q_cmd.amt;
                        end
                        bda_pkg::ACT_REQ:
                        begin
                            if (exceeds || must_wait)
                            begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = exceeds ? bda_pkg::ST_EXCEEDS
                                                          : bda_pkg::ST_WAIT;
                            end
                            else
                            begin
                                // tentative grant, old row kept for rollback
                                bk_alloc_next = rd_alloc;
                                bk_need_next  = rd_need;
                                for (int j = 0; j < NR; j++)
                                begin
                                    free_next[j]            = free_reg[j] - q_cmd.amt[j];
                                    alloc_next[q_cmd.p][j]  = rd_alloc[j] + q_cmd.amt[j];
                                    need_next[q_cmd.p][j]   = rd_need[j] - q_cmd.amt[j];
                                    work_next[j]            = WW'(free_next[j]);
                                end
                                fin_next   = '0;
                                cnt_next   = '0;
                                pass_next  = '0;
                                row_next   = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            for (int j = 0; j < NR; j++)
                                work_next[j] = WW'(free_reg[j]);
                            fin_next   = '0;
                            cnt_next   = '0;
                            pass_next  = '0;
                            row_next   = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one row per cycle
                if (fits)
                begin
                    for (int j = 0; j < NR; j++)
                        work_next[j] = work_reg[j] + WW'(rd_alloc[j]);
                    fin_next[row_reg] = 1'b1;
                    seq_next[cnt_reg[RW-1:0]] = row_reg;
                    cnt_next   = cnt_inc;
                    found_next = 1'b1;
                end
                if (!end_pass)
                begin
                    row_next = row_reg + RW'(1);
                end
                else if ((cnt_next == n_act) || !found_next || (pass_inc >= n_act))
                begin
                    k_next = '0;
                    if (cnt_next == n_act)
                    begin
                        status_next = (q_cmd.action == bda_pkg::ACT_REQ)
                                      ? bda_pkg::ST_GRANTED : bda_pkg::ST_SAFE;
                        state_next  = S_EMIT;
                    end
                    else if (q_cmd.action == bda_pkg::ACT_REQ)
                    begin
                        // roll back the tentative grant
                        status_next         = bda_pkg::ST_DENIED;
                        alloc_next[q_cmd.p] = bk_alloc_reg;
                        need_next[q_cmd.p]  = bk_need_reg;
                        for (int j = 0; j < NR; j++)
                            free_next[j] = free_reg[j] + q_cmd.amt[j];
                        state_next = S_RESP;
                    end
                    else
                    begin
                        status_next = bda_pkg::ST_UNSAFE;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    row_next   = '0;
                    found_next = 1'b0;
                    pass_next  = pass_inc;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_seq_next    = seq_reg[k_reg];
                    out_sv_next     = 1'b1;
                    out_last_next   = (k_reg == n_last);
                    k_next          = k_reg + RW'(1);
                    if (k_reg == n_last)
                    begin
                        q_pop      = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_seq_next    = '0;
                    out_sv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    q_pop           = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            active_reg    <= NW'(bda_pkg::N_ROWS);
            free_reg      <= '0;
            for (int i = 0; i < bda_pkg::N_ROWS; i++)
            begin
                alloc_reg[i] <= '0;
                need_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            free_reg      <= free_next;
            alloc_reg     <= alloc_next;
            need_reg      <= need_next;
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        bk_alloc_reg   <= bk_alloc_next;
        bk_need_reg    <= bk_need_next;
        work_reg       <= work_next;
        fin_reg        <= fin_next;
        seq_reg        <= seq_next;
        cnt_reg        <= cnt_next;
        pass_reg       <= pass_next;
        row_reg        <= row_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_sv_reg     <= out_sv_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.seq_process = out_seq_reg;
    assign out_ch.seq_valid   = out_sv_reg;
    assign out_ch.last        = out_last_reg;

endmodule

FILE: rtl/core/bankers_deadlock_avoidance.sv
// channel   dir  handshake       payload
// in_ch     in   valid/ready     action, process, amount_a..c, held_a..c
// out_ch    out  valid/ready     status, seq_process, seq_valid, last
// cfg       in   cfg_we          cfg_data = active_processes
//
// load row, set available and rejected requests are answered with a single result beat.
// a safety check or a request that passes its checks is scanned one row per
// cycle over up to n passes of n rows, then answered with one beat per sequence
// entry, or a single beat when unsafe or denied; the row-by-row scan in the back end sets the rate.
// reset clears tables, free counts and control; active_processes resets to 8.
// a 2-deep queue holds the command in progress and lets input take one more beat while the back end scans or stalls.
module bankers_deadlock_avoidance (
    input  logic       clk,
    input  logic       rst_n,
    bda_in_if.sink     in_ch,
    bda_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data
);

    logic          q_valid;
    logic          q_pop;
    bda_pkg::cmd_t q_cmd;

    // accept and classify
    bda_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // execute and report
    bda_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_ch   (out_ch)
    );

endmodule

FILE: bench/bda_checker.sv
module bda_checker
    import bda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bda_in_if.sink     in_mon,
    bda_out_if.sink    out_mon,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t    status;
        logic [2:0] seq_process;
        logic       seq_valid;
        logic       last;
    } answer_t;

    // predictor state
    logic [7:0] held_tab [N_ROWS][N_RES];
    logic [7:0] need_tab [N_ROWS][N_RES];
    logic [7:0] free_cnt [N_RES];
    logic [3:0] active_reg;
    answer_t    answers_due [$];

    assign pending = answers_due.size();

    task automatic report(input string what, input answer_t got, input answer_t want);
        fail_count++;
        $display("mismatch %s: got st=%0d p=%0d v=%0d l=%0d want st=%0d p=%0d v=%0d l=%0d",
                 what, got.status, got.seq_process, got.seq_valid, got.last,
                 want.status, want.seq_process, want.seq_valid, want.last);
    endtask

    function automatic int rows_active();
        int n;
        n = active_reg;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    // banker's safety scan over the active rows, returns finish order length
    function automatic int scan_safe(input int n, output int order[8]);
        logic [11:0] work [N_RES];
        bit fin [8];
        bit found, fits;
        int cnt;
        cnt = 0;
        for (int i = 0; i < 8; i++) fin[i] = 0;
        for (int j = 0; j < N_RES; j++) work[j] = 12'(free_cnt[j]);
        for (int ps = 0; ps < n && cnt < n; ps++)
        begin
            found = 0;
            for (int i = 0; i < n; i++)
            begin
                if (fin[i]) continue;
                fits = 1;
                for (int j = 0; j < N_RES; j++)
                    if (12'(need_tab[i][j]) > work[j]) fits = 0;
                if (fits)
                begin
                    for (int j = 0; j < N_RES; j++) work[j] = work[j] + 12'(held_tab[i][j]);
                    fin[i] = 1;
                    order[cnt] = i;
                    cnt++;
                    found = 1;
                end
            end
            if (!found) break;
        end
        return cnt;
    endfunction

    function automatic void push_one(input status_t st);
        answer_t a;
        a.status = st;
        a.seq_process = '0;
        a.seq_valid = 0;
        a.last = 1;
        answers_due.push_back(a);
    endfunction

    function automatic void push_order(input status_t st, input int order[8], input int n);
        answer_t a;
        for (int k = 0; k < n; k++)
        begin
            a.status = st;
            a.seq_process = 3'(order[k]);
            a.seq_valid = 1;
            a.last = (k == n - 1);
            answers_due.push_back(a);
        end
    endfunction

    function automatic void predict(input act_t act, input logic [2:0] p,
                                    input logic [7:0] amt[N_RES], input logic [7:0] hld[N_RES]);
        int order[8];
        int n, cnt;
        bit bad;
        n = rows_active();
        case (act)
            ACT_LOAD:
            begin
                bad = 0;
                for (int j = 0; j < N_RES; j++) if (hld[j] > amt[j]) bad = 1;
                if (bad) push_one(ST_BAD_ROW);
                else
                begin
                    for (int j = 0; j < N_RES; j++)
                    begin
                        held_tab[p][j] = hld[j];
                        need_tab[p][j] = amt[j] - hld[j];
                    end
                    push_one(ST_LOADED);
                end
            end
            ACT_AVAIL:
            begin
                for (int j = 0; j < N_RES; j++) free_cnt[j] = amt[j];
                push_one(ST_LOADED);
            end
            ACT_REQ:
            begin
                bad = 0;
                for (int j = 0; j < N_RES; j++) if (amt[j] > need_tab[p][j]) bad = 1;
                if (bad) push_one(ST_EXCEEDS);
                else
                begin
                    for (int j = 0; j < N_RES; j++) if (amt[j] > free_cnt[j]) bad = 1;
                    if (bad) push_one(ST_WAIT);
                    else
                    begin
                        for (int j = 0; j < N_RES; j++)
                        begin
                            free_cnt[j] -= amt[j];
                            held_tab[p][j] += amt[j];
                            need_tab[p][j] -= amt[j];
                        end
                        cnt = scan_safe(n, order);
                        if (cnt == n) push_order(ST_GRANTED, order, n);
                        else
                        begin
                            // roll back the tentative grant
                            for (int j = 0; j < N_RES; j++)
                            begin
                                free_cnt[j] += amt[j];
                                held_tab[p][j] -= amt[j];
                                need_tab[p][j] += amt[j];
                            end
                            push_one(ST_DENIED);
                        end
                    end
                end
            end
            default:
            begin
                cnt = scan_safe(n, order);
                if (cnt == n) push_order(ST_SAFE, order, n);
                else push_one(ST_UNSAFE);
            end
        endcase
    endfunction

    // watch input beats, output beats and register writes
    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] amt[N_RES];
        logic [7:0] hld[N_RES];
        answer_t got, want;
        if (!rst_n)
        begin
            for (int i = 0; i < N_ROWS; i++)
                for (int j = 0; j < N_RES; j++)
                begin
                    held_tab[i][j] = 0;
                    need_tab[i][j] = 0;
                end
            for (int j = 0; j < N_RES; j++) free_cnt[j] = 0;
            active_reg = 8;
            answers_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got.status = status_t'(out_mon.status);
                got.seq_process = out_mon.seq_process;
                got.seq_valid = out_mon.seq_valid;
                got.last = out_mon.last;
                if (answers_due.size() == 0)
                begin
                    want = '0;
                    report("unexpected beat", got, want);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.status != want.status) report("status", got, want);
                    else if (got.seq_process != want.seq_process) report("seq_process", got, want);
                    else if (got.seq_valid != want.seq_valid) report("seq_valid", got, want);
                    else if (got.last != want.last) report("last", got, want);
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                amt[0] = in_mon.amount_a; amt[1] = in_mon.amount_b; amt[2] = in_mon.amount_c;
                hld[0] = in_mon.held_a;   hld[1] = in_mon.held_b;   hld[2] = in_mon.held_c;
                predict(act_t'(in_mon.action), in_mon.process, amt, hld);
            end
            if (cfg_we) active_reg = cfg_data;
        end
    end
endmodule

FILE: bench/tb_top.sv
module tb_top;
    import bda_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [3:0] cfg_data = 4'd8;
    int fail_count;
    int pending;
    int idle_in_pct = 0;
    int stall_out_pct = 0;
    int quiet_cycles = 0;

    bda_in_if  in_ch();
    bda_out_if out_ch();

    bankers_deadlock_avoidance uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    bda_checker chk (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.action = 0;
        in_ch.process = 0;
        in_ch.amount_a = 0; in_ch.amount_b = 0; in_ch.amount_c = 0;
        in_ch.held_a = 0;   in_ch.held_b = 0;   in_ch.held_c = 0;
        out_ch.ready = 0;
    end

    // receiver stalls at random
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_out_pct);

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays up after a beat until the next send or an idle step drops it
    task automatic send(input act_t act, input int p, input int a, input int b, input int c,
                        input int ha, input int hb, input int hc);
        while ($urandom_range(99) < idle_in_pct)
        begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.action <= act;
        in_ch.process <= 3'(p);
        in_ch.amount_a <= 8'(a); in_ch.amount_b <= 8'(b); in_ch.amount_c <= 8'(c);
        in_ch.held_a <= 8'(ha);  in_ch.held_b <= 8'(hb);  in_ch.held_c <= 8'(hc);
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_active(input int n);
        drain();
        cfg_we <= 1;
        cfg_data <= 4'(n);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // one row loaded with small claims so scans usually succeed
    task automatic load_small(input int p);
        int ha, hb, hc;
        ha = $urandom_range(5); hb = $urandom_range(5); hc = $urandom_range(5);
        send(ACT_LOAD, p, ha + $urandom_range(6), hb + $urandom_range(6),
             hc + $urandom_range(6), ha, hb, hc);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) load_small($urandom_range(7));
        else if (pick < 30) send(ACT_AVAIL, 0, $urandom_range(12), $urandom_range(12),
                                 $urandom_range(12), $urandom_range(255), 0, 0);
        else if (pick < 65) send(ACT_REQ, $urandom_range(7), $urandom_range(4),
                                 $urandom_range(4), $urandom_range(4), 0, 0, 0);
        else if (pick < 85) send(ACT_CHECK, $urandom_range(7), $urandom_range(255),
                                 $urandom_range(255), $urandom_range(255), 0, 0, 0);
        else
        begin
            // noise across full field ranges
            send(act_t'($urandom_range(3)), $urandom_range(7), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255));
        end
    endtask

    initial
    begin
        int phase_pct[4][2];
        phase_pct = '{'{0, 0}, '{68, 0}, '{0, 68}, '{31, 31}};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty tables are safe, then extremes and each outcome
        send(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_LOAD, 0, 255, 255, 255, 255, 255, 255);
        send(ACT_LOAD, 1, 255, 255, 255, 0, 0, 0);
        send(ACT_LOAD, 2, 3, 3, 3, 4, 0, 0);
        send(ACT_LOAD, 3, 0, 0, 0, 0, 0, 1);
        send(ACT_AVAIL, 0, 255, 255, 255, 0, 0, 0);
        send(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_REQ, 1, 10, 10, 10, 0, 0, 0);
        send(ACT_REQ, 2, 1, 0, 0, 0, 0, 0);
        send(ACT_AVAIL, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_REQ, 1, 1, 0, 0, 0, 0, 0);
        send(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_AVAIL, 0, 2, 2, 2, 0, 0, 0);
        send(ACT_REQ, 1, 2, 2, 2, 0, 0, 0);
        send(ACT_LOAD, 1, 0, 0, 0, 0, 0, 0);
        send(ACT_LOAD, 7, 170, 85, 1, 85, 85, 0);
        set_active(1);
        send(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_REQ, 7, 1, 0, 1, 0, 0, 0);
        set_active(15);
        send(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);
        set_active(0);
        send(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);

        // random phases with different idle mixes and register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            set_active(ph == 7 ? 8 : $urandom_range(1, 8));
            idle_in_pct = phase_pct[ph % 4][0];
            stall_out_pct = phase_pct[ph % 4][1];
            for (int r = 0; r < 8; r++) load_small(r);
            send(ACT_AVAIL, 0, 8 + $urandom_range(8), 8 + $urandom_range(8),
                 8 + $urandom_range(8), 0, 0, 0);
            for (int k = 0; k < 46; k++)
            begin
                random_item();
                // sender holds off until every answer is back
                if (k == 20 && ph == 2)
                begin
                    in_ch.valid <= 0;
                    @(negedge clk);
                    while (pending != 0) @(negedge clk);
                end
            end
        end

        idle_in_pct = 0;
        stall_out_pct = 0;
        drain();
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
